[src/sps_pkg.sv]
package sps_pkg;

    localparam logic [63:0] RPIBY2   = 64'h3fe45f306dc9c883;
    localparam logic [63:0] PIO2_HI  = 64'h3ff921fb50000000;
    localparam logic [63:0] PIO2_LO  = 64'h3e5110b4611a6263;
    localparam logic [63:0] HALF_POS = 64'h3fe0000000000000;
    localparam logic [63:0] HALF_NEG = 64'hbfe0000000000000;

    localparam logic [63:0] SIN_C0 = 64'h3ff0000000000000;
    localparam logic [63:0] SIN_C1 = 64'hbfc555545268a030;
    localparam logic [63:0] SIN_C2 = 64'h3f811073afd14db9;
    localparam logic [63:0] SIN_C3 = 64'hbf29943e0fc79aa9;
    localparam logic [63:0] COS_C0 = 64'h3ff0000000000000;
    localparam logic [63:0] COS_C1 = 64'hbfdffffb2a77e083;
    localparam logic [63:0] COS_C2 = 64'h3fa553e7f02ac8aa;
    localparam logic [63:0] COS_C3 = 64'hbf5644d62993c4ad;

    localparam logic [31:0] QNAN_F    = 32'h7fc00000;
    localparam logic [31:0] TWO_P28_F = 32'h4d800000;

    localparam int MUL_LAT = 4;
    localparam int ADD_LAT = 6;

    typedef struct packed {
        logic [63:0] dx;
        logic        nan;
        logic        last;
    } t_entry;

endpackage

[src/sps_front.sv]
module sps_front (
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [31:0]     i_arg_bits,
    input  logic            i_last_in,
    input  logic            i_full,
    output logic            o_push,
    output sps_pkg::t_entry o_entry
);
    import sps_pkg::*;

    logic [30:0] mag;
    logic        is_nan;
    logic        to_zero;
    logic [4:0]  top;
    logic [22:0] frac_n;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        mag     = i_arg_bits[30:0];
        is_nan  = mag > 31'h7f800000;
        to_zero = is_nan || (mag >= TWO_P28_F[30:0]);
        top     = '0;
        for (int k = 0; k < 23; k++) begin
            if (i_arg_bits[k]) begin
                top = 5'(k);
            end
        end
        frac_n = i_arg_bits[22:0] << (5'd23 - top);

        o_entry.nan  = is_nan;
        o_entry.last = i_last_in;
        if (to_zero) begin
            o_entry.dx = '0;
        end else if (i_arg_bits[30:23] == 8'd0) begin
            if (i_arg_bits[22:0] == 23'd0) begin
                o_entry.dx = {i_arg_bits[31], 63'd0};
            end else begin
                o_entry.dx = {i_arg_bits[31], 11'(top) + 11'd874, frac_n, 29'd0};
            end
        end else begin
            o_entry.dx = {i_arg_bits[31], {3'd0, i_arg_bits[30:23]} + 11'd896,
                          i_arg_bits[22:0], 29'd0};
        end
    end

endmodule

[src/sps_fifo.sv]
module sps_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sps_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output sps_pkg::t_entry o_entry
);
    import sps_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]   r_count, n_count;
    logic            push_ok, pop_ok;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_entry    = r_mem[r_rp];
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_pop && o_nonempty;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (push_ok) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop_ok) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !push_ok) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count not decremented on pop");

endmodule

[src/sps_fmul.sv]
module sps_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [52:0]  ma, mb;
    logic [53:0]  r1_hh;
    logic [52:0]  r1_hl, r1_lh;
    logic [51:0]  r1_ll;
    logic [11:0]  r1_exp, r2_exp, r3_exp;
    logic         r1_sign, r2_sign, r3_sign;
    logic         r1_zero, r2_zero, r3_zero;
    logic [53:0]  r2_hh, r2_mid;
    logic [51:0]  r2_ll;
    logic [105:0] r3_p;
    logic [63:0]  r4_p;

    logic [52:0]  mant;
    logic         g, st, up;
    logic [53:0]  rnd;
    logic [11:0]  ex, expo;
    logic [51:0]  frac;

    assign ma = {|i_a[62:52], i_a[51:0]};
    assign mb = {|i_b[62:52], i_b[51:0]};

    always_comb begin
        if (r3_p[105]) begin
            mant = r3_p[105:53];
            g    = r3_p[52];
            st   = |r3_p[51:0];
            ex   = r3_exp + 12'd1;
        end else begin
            mant = r3_p[104:52];
            g    = r3_p[51];
            st   = |r3_p[50:0];
            ex   = r3_exp;
        end
        up  = g && (st || mant[0]);
        rnd = {1'b0, mant} + 54'(up);
        if (rnd[53]) begin
            ex   = ex + 12'd1;
            frac = '0;
        end else begin
            frac = rnd[51:0];
        end
        expo = ex - 12'd1023;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hh   <= ma[52:26] * mb[52:26];
            r1_hl   <= ma[52:26] * mb[25:0];
            r1_lh   <= ma[25:0] * mb[52:26];
            r1_ll   <= ma[25:0] * mb[25:0];
            r1_exp  <= {1'b0, i_a[62:52]} + {1'b0, i_b[62:52]};
            r1_sign <= i_a[63] ^ i_b[63];
            r1_zero <= (i_a[62:52] == 11'd0) || (i_b[62:52] == 11'd0);

            r2_hh   <= r1_hh;
            r2_ll   <= r1_ll;
            r2_mid  <= 54'(r1_hl) + 54'(r1_lh);
            r2_exp  <= r1_exp;
            r2_sign <= r1_sign;
            r2_zero <= r1_zero;

            r3_p    <= {r2_hh, r2_ll} + {26'd0, r2_mid, 26'd0};
            r3_exp  <= r2_exp;
            r3_sign <= r2_sign;
            r3_zero <= r2_zero;

            r4_p    <= r3_zero ? {r3_sign, 63'd0} : {r3_sign, expo[10:0], frac};
        end
    end

    assign o_p = r4_p;

endmodule

[src/sps_fadd.sv]
module sps_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_s
);
    logic [63:0]  big, sml;
    logic         r1_sb, r1_ss, r1_bz, r1_zs;
    logic [11:0]  r1_eb;
    logic [52:0]  r1_mb, r1_ms;
    logic [10:0]  r1_d;

    logic [5:0]   shamt;
    logic [111:0] ext;
    logic         r2_sb, r2_sub, r2_bz, r2_zs;
    logic [11:0]  r2_eb;
    logic [55:0]  r2_mb, r2_ms;

    logic         r3_sb, r3_bz, r3_zs;
    logic [11:0]  r3_eb;
    logic [56:0]  r3_sum;

    logic [5:0]   lz;
    logic         r4_sb, r4_bz, r4_zs;
    logic [11:0]  r4_eb;
    logic [56:0]  r4_sum;
    logic [5:0]   r4_lz;

    logic         r5_sb, r5_bz, r5_zs, r5_zero;
    logic [11:0]  r5_ex;
    logic [55:0]  r5_m;

    logic [52:0]  mant;
    logic         up;
    logic [53:0]  rnd;
    logic [11:0]  ex6;
    logic [51:0]  frac;
    logic [63:0]  r6_s;

    always_comb begin
        if (i_a[62:0] >= i_b[62:0]) begin
            big = i_a;
            sml = i_b;
        end else begin
            big = i_b;
            sml = i_a;
        end
        shamt = (r1_d > 11'd63) ? 6'd63 : r1_d[5:0];
        ext   = {r1_ms, 3'd0, 56'd0} >> shamt;
        lz    = '0;
        for (int k = 0; k < 56; k++) begin
            if (r3_sum[k]) begin
                lz = 6'(55 - k);
            end
        end
        mant = r5_m[55:3];
        up   = r5_m[2] && (r5_m[1] || r5_m[0] || mant[0]);
        rnd  = {1'b0, mant} + 54'(up);
        if (rnd[53]) begin
            ex6  = r5_ex + 12'd1;
            frac = '0;
        end else begin
            ex6  = r5_ex;
            frac = rnd[51:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sb  <= big[63];
            r1_ss  <= sml[63];
            r1_eb  <= {1'b0, big[62:52]};
            r1_mb  <= {|big[62:52], big[51:0]};
            r1_ms  <= {|sml[62:52], sml[51:0]};
            r1_d   <= big[62:52] - sml[62:52];
            r1_bz  <= (big[62:52] == 11'd0);
            r1_zs  <= big[63] & sml[63];

            r2_sb  <= r1_sb;
            r2_sub <= r1_sb ^ r1_ss;
            r2_eb  <= r1_eb;
            r2_mb  <= {r1_mb, 3'd0};
            r2_ms  <= {ext[111:57], ext[56] | (|ext[55:0])};
            r2_bz  <= r1_bz;
            r2_zs  <= r1_zs;

            r3_sb  <= r2_sb;
            r3_eb  <= r2_eb;
            r3_sum <= r2_sub ? {1'b0, r2_mb} - {1'b0, r2_ms} : {1'b0, r2_mb} + {1'b0, r2_ms};
            r3_bz  <= r2_bz;
            r3_zs  <= r2_zs;

            r4_sb  <= r3_sb;
            r4_eb  <= r3_eb;
            r4_sum <= r3_sum;
            r4_lz  <= lz;
            r4_bz  <= r3_bz;
            r4_zs  <= r3_zs;

            r5_sb   <= r4_sb;
            r5_bz   <= r4_bz;
            r5_zs   <= r4_zs;
            r5_zero <= (r4_sum == 57'd0);
            if (r4_sum[56]) begin
                r5_m  <= {r4_sum[56:2], r4_sum[1] | r4_sum[0]};
                r5_ex <= r4_eb + 12'd1;
            end else begin
                r5_m  <= r4_sum[55:0] << r4_lz;
                r5_ex <= r4_eb - 12'(r4_lz);
            end

            if (r5_zero) begin
                r6_s <= {r5_bz ? r5_zs : 1'b0, 63'd0};
            end else begin
                r6_s <= {r5_sb, ex6[10:0], frac};
            end
        end
    end

    assign o_s = r6_s;

endmodule

[src/sps_back.sv]
module sps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  sps_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_sine_bits,
    output logic            o_last_out
);
    import sps_pkg::*;

    localparam int T_DN  = MUL_LAT;
    localparam int T_V   = T_DN + ADD_LAT;
    localparam int T_NQ  = T_V + 1;
    localparam int T_P   = T_NQ + MUL_LAT;
    localparam int T_X1  = T_P + ADD_LAT;
    localparam int T_X2  = T_X1 + ADD_LAT;
    localparam int T_XSQ = T_X2 + MUL_LAT;
    localparam int T_M1  = T_XSQ + MUL_LAT;
    localparam int T_A1  = T_M1 + ADD_LAT;
    localparam int T_M2  = T_A1 + MUL_LAT;
    localparam int T_A2  = T_M2 + ADD_LAT;
    localparam int T_M3  = T_A2 + MUL_LAT;
    localparam int T_A3  = T_M3 + ADD_LAT;

    localparam int DX_DLY   = T_P;
    localparam int P2_DLY   = ADD_LAT;
    localparam int XSQ_DLY  = T_A2 - T_XSQ;
    localparam int XSQ_TAP  = T_A1 - T_XSQ - 1;
    localparam int X2_DLY   = T_M3 - T_X2;
    localparam int X2_TAP   = T_XSQ - T_X2 - 1;
    localparam int X3_DLY   = T_A2 - T_M1;
    localparam int NB_DLY   = T_A3 - T_NQ;
    localparam int SIDE_DLY = T_A3;

    logic        en;
    logic        r_vld [T_A3 + 1];
    logic        r_ov;
    t_entry      r_s0;
    logic [31:0] r_out;
    logic        r_olast;

    logic [63:0] dn, v, p1, p2, x1, x2, xsq;
    logic [63:0] cm1, ca1, cm2, ca2, cm3, cp;
    logic [63:0] sm1, sa1, sm2, sa2, x3, sm3, sp;

    logic [63:0] r_dnq;
    logic [1:0]  r_nb;
    logic [63:0] r_dx_dl  [DX_DLY];
    logic [63:0] r_p2_dl  [P2_DLY];
    logic [63:0] r_xsq_dl [XSQ_DLY];
    logic [63:0] r_x2_dl  [X2_DLY];
    logic [63:0] r_x3_dl  [X3_DLY];
    logic [1:0]  r_nb_dl  [NB_DLY];
    logic        r_nan_dl [SIDE_DLY];
    logic        r_last_dl [SIDE_DLY];

    logic [10:0]  ev;
    logic [5:0]   tsh;
    logic [52:0]  nint;
    logic [63:0]  dnq;
    logic [1:0]   nlo, nb;

    logic [63:0]  pick;
    logic [10:0]  pe;
    logic [5:0]   fsh;
    logic [116:0] fext;
    logic [30:0]  body;
    logic         fg, fst, flsb, fup;
    logic [31:0]  fbits, res;

    function automatic logic [63:0] dn_half(input logic [63:0] d);
        return (!d[63] || (d[62:0] == 63'd0)) ? HALF_POS : HALF_NEG;
    endfunction

    assign en          = !r_ov || i_out_ready;
    assign o_pop       = en;
    assign o_out_valid = r_ov;
    assign o_sine_bits = r_out;
    assign o_last_out  = r_olast;

    sps_fmul u_mul_dn  (.i_clk, .i_en(en), .i_a(r_s0.dx), .i_b(RPIBY2), .o_p(dn));
    sps_fadd u_add_v   (.i_clk, .i_en(en), .i_a(dn), .i_b(dn_half(dn)), .o_s(v));
    sps_fmul u_mul_p1  (.i_clk, .i_en(en), .i_a(r_dnq), .i_b(PIO2_HI), .o_p(p1));
    sps_fmul u_mul_p2  (.i_clk, .i_en(en), .i_a(r_dnq), .i_b(PIO2_LO), .o_p(p2));
    sps_fadd u_add_x1  (.i_clk, .i_en(en), .i_a(r_dx_dl[DX_DLY-1]),
                        .i_b({~p1[63], p1[62:0]}), .o_s(x1));
    sps_fadd u_add_x2  (.i_clk, .i_en(en), .i_a(x1),
                        .i_b({~r_p2_dl[P2_DLY-1][63], r_p2_dl[P2_DLY-1][62:0]}), .o_s(x2));
    sps_fmul u_mul_xsq (.i_clk, .i_en(en), .i_a(x2), .i_b(x2), .o_p(xsq));

    sps_fmul u_mul_c1  (.i_clk, .i_en(en), .i_a(COS_C3), .i_b(xsq), .o_p(cm1));
    sps_fadd u_add_c1  (.i_clk, .i_en(en), .i_a(cm1), .i_b(COS_C2), .o_s(ca1));
    sps_fmul u_mul_c2  (.i_clk, .i_en(en), .i_a(ca1), .i_b(r_xsq_dl[XSQ_TAP]), .o_p(cm2));
    sps_fadd u_add_c2  (.i_clk, .i_en(en), .i_a(cm2), .i_b(COS_C1), .o_s(ca2));
    sps_fmul u_mul_c3  (.i_clk, .i_en(en), .i_a(ca2), .i_b(r_xsq_dl[XSQ_DLY-1]), .o_p(cm3));
    sps_fadd u_add_c3  (.i_clk, .i_en(en), .i_a(cm3), .i_b(COS_C0), .o_s(cp));

    sps_fmul u_mul_s1  (.i_clk, .i_en(en), .i_a(SIN_C3), .i_b(xsq), .o_p(sm1));
    sps_fadd u_add_s1  (.i_clk, .i_en(en), .i_a(sm1), .i_b(SIN_C2), .o_s(sa1));
    sps_fmul u_mul_s2  (.i_clk, .i_en(en), .i_a(sa1), .i_b(r_xsq_dl[XSQ_TAP]), .o_p(sm2));
    sps_fadd u_add_s2  (.i_clk, .i_en(en), .i_a(sm2), .i_b(SIN_C1), .o_s(sa2));
    sps_fmul u_mul_x3  (.i_clk, .i_en(en), .i_a(xsq), .i_b(r_x2_dl[X2_TAP]), .o_p(x3));
    sps_fmul u_mul_s3  (.i_clk, .i_en(en), .i_a(sa2), .i_b(r_x3_dl[X3_DLY-1]), .o_p(sm3));
    sps_fadd u_add_s3  (.i_clk, .i_en(en), .i_a(sm3), .i_b(r_x2_dl[X2_DLY-1]), .o_s(sp));

    // truncate toward zero and keep the low two bits of n
    always_comb begin
        ev   = v[62:52];
        tsh  = (ev >= 11'd1075) ? 6'd0 : 6'(11'd1075 - ev);
        nint = {1'b1, v[51:0]} >> tsh;
        if (ev < 11'd1023) begin
            dnq = '0;
            nlo = '0;
        end else begin
            dnq = {v[63], v[62:52], v[51:0] & ({52{1'b1}} << tsh)};
            nlo = nint[1:0];
        end
        nb = v[63] ? (~nlo + 2'd1) : nlo;
    end

    // pick cosine or sine on bit 0 of n, round to single, negate on bit 1 of n, quiet NaN for a NaN argument
    always_comb begin
        pick = r_nb_dl[NB_DLY-1][0] ? cp : sp;
        pe   = pick[62:52];
        fsh  = (pe < 11'd863) ? 6'd63 : 6'(11'd926 - pe);
        fext = {1'b1, pick[51:0], 64'd0} >> fsh;
        if (pe == 11'd0) begin
            body = '0;
            fg   = 1'b0;
            fst  = 1'b0;
            flsb = 1'b0;
        end else if (pe >= 11'd897) begin
            body = {8'(pe - 11'd896), pick[51:29]};
            fg   = pick[28];
            fst  = |pick[27:0];
            flsb = pick[29];
        end else begin
            body = {8'd0, fext[86:64]};
            fg   = fext[63];
            fst  = |fext[62:0];
            flsb = fext[64];
        end
        fup   = fg && (fst || flsb);
        fbits = {pick[63], body + 31'(fup)};
        res   = r_nan_dl[SIDE_DLY-1] ? QNAN_F
                : (fbits ^ {r_nb_dl[NB_DLY-1][1], 31'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= T_A3; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_nonempty;
            for (int k = 1; k <= T_A3; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ov <= r_vld[T_A3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0    <= i_entry;
            r_dnq   <= dnq;
            r_nb    <= nb;
            r_out   <= res;
            r_olast <= r_last_dl[SIDE_DLY-1];

            r_dx_dl[0]   <= r_s0.dx;
            r_p2_dl[0]   <= p2;
            r_xsq_dl[0]  <= xsq;
            r_x2_dl[0]   <= x2;
            r_x3_dl[0]   <= x3;
            r_nb_dl[0]   <= r_nb;
            r_nan_dl[0]  <= r_s0.nan;
            r_last_dl[0] <= r_s0.last;
            for (int k = 1; k < DX_DLY; k++)   r_dx_dl[k]   <= r_dx_dl[k-1];
            for (int k = 1; k < P2_DLY; k++)   r_p2_dl[k]   <= r_p2_dl[k-1];
            for (int k = 1; k < XSQ_DLY; k++)  r_xsq_dl[k]  <= r_xsq_dl[k-1];
            for (int k = 1; k < X2_DLY; k++)   r_x2_dl[k]   <= r_x2_dl[k-1];
            for (int k = 1; k < X3_DLY; k++)   r_x3_dl[k]   <= r_x3_dl[k-1];
            for (int k = 1; k < NB_DLY; k++)   r_nb_dl[k]   <= r_nb_dl[k-1];
            for (int k = 1; k < SIDE_DLY; k++) r_nan_dl[k]  <= r_nan_dl[k-1];
            for (int k = 1; k < SIDE_DLY; k++) r_last_dl[k] <= r_last_dl[k-1];
        end
    end

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_vld[0] == $past(r_vld[0])) && (r_vld[T_A3] == $past(r_vld[T_A3])))
        else $error("pipeline advanced while stalled");

    a_nan_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[T_A3] && r_nan_dl[SIDE_DLY-1]) |=> (r_out == QNAN_F))
        else $error("NaN argument did not give quiet NaN");

endmodule

[src/single_precision_sine.sv]
// Single-precision sine, one transaction per cycle while no result waits on i_out_ready.
// Input channel: i_in_valid / o_in_ready carry i_arg_bits (binary32) and
// i_last_in. Output channel: o_out_valid / i_out_ready carry o_sine_bits
// (binary32) and o_last_out, the marker of the same element.
// The front classifies the argument (NaN, magnitude of 2^28 or more) and
// widens it to double into a queue of QUEUE_DEPTH entries. The back runs
// the reduction and both polynomials in a 62-stage double-precision
// pipeline of multipliers (4 stages, partial products of 27- and 26-bit halves) and adders
// (6 stages).
// Throughput: one element per cycle while no result waits on i_out_ready, set by the fully pipelined back end.
// When a result waits with i_out_ready low, the back pipeline and the output
// register hold; the queue keeps taking inputs until it is full, then
// o_in_ready drops. Results leave in input order.
// Reset (synchronous, active low) empties the queue and drops all
// elements in flight; the data registers are not reset.
module single_precision_sine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_arg_bits,
    input  logic        i_last_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sine_bits,
    output logic        o_last_out
);
    import sps_pkg::*;

    t_entry wr_entry, rd_entry;
    logic   push, full, pop, nonempty;

    sps_front u_front (
        .i_in_valid,
        .o_in_ready,
        .i_arg_bits,
        .i_last_in,
        .i_full  (full),
        .o_push  (push),
        .o_entry (wr_entry)
    );

    sps_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk,
        .i_rst_n,
        .i_push     (push),
        .i_entry    (wr_entry),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_entry    (rd_entry)
    );

    sps_back u_back (
        .i_clk,
        .i_rst_n,
        .i_nonempty (nonempty),
        .i_entry    (rd_entry),
        .o_pop      (pop),
        .o_out_valid,
        .i_out_ready,
        .o_sine_bits,
        .o_last_out
    );

endmodule
